>>> rtl/core/mclw_pkg.sv
`timescale 1ns / 1ps

package mclw_pkg;

  localparam int CHANNEL_COUNT       = 13;
  localparam int CALIBRATION_CHANNEL = 12;

  localparam int CMD_W   = 2;
  localparam int CH_W    = 4;
  localparam int CNT_W   = 8;
  localparam int FLAGS_W = 13;
  // Wide enough to compare the channel field against any bank index.
  localparam int CIDX_W  = 6;

  localparam logic [CNT_W-1:0] LIMIT_DEFAULT = CNT_W'(200);
  localparam logic [CNT_W-1:0] LIMIT_LONG    = CNT_W'(100);
  localparam logic [CNT_W-1:0] LIMIT_SHORT   = CNT_W'(20);

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 2'd0,
    CMD_FEED  = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [CH_W-1:0]  channel;
    logic             params_saved;
  } in_t;

  typedef struct packed {
    logic [FLAGS_W-1:0] lost_flags;
    logic               channel_lost;
  } out_t;

  // Fixed timeout of each channel, in ticks.
  function automatic logic [CNT_W-1:0] limit_of(input int idx);
    logic [CNT_W-1:0] lim;
    lim = LIMIT_DEFAULT;
    if (idx == 10 || idx == 12) begin
      lim = LIMIT_LONG;
    end else if (idx == 11) begin
      lim = LIMIT_SHORT;
    end
    return lim;
  endfunction

endpackage

>>> rtl/core/mclw_bank.sv
`timescale 1ns / 1ps

module mclw_bank (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  mclw_pkg::in_t item_i,
  output mclw_pkg::out_t result_o
);
  import mclw_pkg::*;

  logic [CNT_W-1:0]         cnt_q [CHANNEL_COUNT];
  logic [CNT_W-1:0]         cnt_d [CHANNEL_COUNT];
  logic [CNT_W-1:0]         tick_next [CHANNEL_COUNT];
  logic [CHANNEL_COUNT-1:0] lost_q;
  logic [CHANNEL_COUNT-1:0] lost_d;
  logic [CHANNEL_COUNT-1:0] hit;
  logic                     queried;

  always_comb begin
    lost_d  = lost_q;
    queried = 1'b0;
    for (int i = 0; i < CHANNEL_COUNT; i++) begin
      cnt_d[i]     = cnt_q[i];
      tick_next[i] = cnt_q[i] + CNT_W'(1);
      hit[i]       = ({{(CIDX_W-CH_W){1'b0}}, item_i.channel} == CIDX_W'(i));
      if (en_i) begin
        case (cmd_e'(item_i.command))
          CMD_TICK: begin
            if (tick_next[i] >= limit_of(i)) begin
              cnt_d[i]  = '0;
              lost_d[i] = 1'b1;
            end else begin
              cnt_d[i] = tick_next[i];
            end
            // The calibration feed comes after the timeout check.
            if (item_i.params_saved && i == CALIBRATION_CHANNEL) begin
              cnt_d[i]  = '0;
              lost_d[i] = 1'b0;
            end
          end
          CMD_FEED: begin
            if (hit[i]) begin
              cnt_d[i]  = '0;
              lost_d[i] = 1'b0;
            end
          end
          CMD_QUERY: begin
            if (hit[i]) begin
              queried = lost_q[i];
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    result_o.lost_flags = '0;
    for (int i = 0; i < FLAGS_W; i++) begin
      if (i < CHANNEL_COUNT) begin
        result_o.lost_flags[i] = lost_d[i];
      end
    end
    result_o.channel_lost = queried;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lost_q <= '0;
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      lost_q <= lost_d;
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        cnt_q[i] <= cnt_d[i];
      end
    end
  end

endmodule

>>> rtl/core/multi_channel_link_watchdog.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake             Payload
// in        input      in_valid_i/in_stall_o  in_data_i  (command, channel, params_saved)
// out       output     out_valid_o/out_stall_i out_data_o (lost_flags, channel_lost)
//
// One transaction per cycle is sustained while out_stall_i stays low; an accepted
// input passes the input register and then the result register, from which its
// result is offered.
// All channel counters update in parallel in the bank, so no command waits on another.
// Reset clears every counter, every lost flag and the valid bits of both pipeline registers; their data is not reset.
// A stall on the output holds the result register; the input register then
// holds one more transaction before in_stall_o rises.

module multi_channel_link_watchdog (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  mclw_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output mclw_pkg::out_t out_data_o
);
  import mclw_pkg::*;

  logic in_valid_q;
  in_t  in_data_q;
  logic out_valid_q;
  out_t out_data_q;
  logic out_ready;
  logic advance;
  out_t result;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;

  // The bank commits its state update only when the result moves on.
  mclw_bank u_bank (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .item_i   (in_data_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_ready) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_data_q <= in_data_i;
    end
    if (advance) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> rtl/core/mclw_checker.sv
`timescale 1ns / 1ps

module mclw_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input mclw_pkg::in_t  in_data_i,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input mclw_pkg::out_t out_data_o
);
  import mclw_pkg::*;

  // A stalled input transaction stays offered and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("input changed while stalled");

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("stalled result changed");

  // With the output empty the input side must never stall.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with an empty output");

  // A reported lost channel must also show in the flag vector.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.channel_lost |-> out_data_o.lost_flags != '0)
    else $error("channel_lost set with no lost flags");

endmodule

bind multi_channel_link_watchdog mclw_checker u_mclw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
